>>> rtl/core/pfc_pkg.sv
`timescale 1ns / 1ps
// Shared types, format codes and constants for the pixel format converter.
package pfc_pkg;

  typedef enum logic [2:0] {
    FMT_RGBA8888 = 3'd0,
    FMT_RGB888   = 3'd1,
    FMT_RGB565   = 3'd2,
    FMT_RGBA4444 = 3'd3,
    FMT_RGB5A1   = 3'd4,
    FMT_AI88     = 3'd5,
    FMT_A8       = 3'd6,
    FMT_I8       = 3'd7
  } fmt_t;

  typedef enum logic {
    REG_SOURCE_FORMAT = 1'b0,
    REG_TARGET_FORMAT = 1'b1
  } reg_idx_t;

  localparam int PADDR_W = 3;

  // Luminance weights; the sum is below 2^18
  localparam int LUMA_SUM_W = 18;
  localparam logic [LUMA_SUM_W-1:0] LUMA_WR    = 18'd299;
  localparam logic [LUMA_SUM_W-1:0] LUMA_WG    = 18'd587;
  localparam logic [LUMA_SUM_W-1:0] LUMA_WB    = 18'd114;
  localparam logic [LUMA_SUM_W-1:0] LUMA_ROUND = 18'd500;

  // Exact divide by 1000 over the sum range: ceil(2^28 / 1000)
  localparam int LUMA_RECIP_W = 19;
  localparam int LUMA_SHIFT   = 28;
  localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 19'd268436;
  localparam int LUMA_PROD_W  = LUMA_SUM_W + LUMA_RECIP_W;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    fmt_t source_format;
    fmt_t target_format;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic [2:0]  out_bytes;
    fmt_t        format_used;
    logic        fell_back;
    logic        last_out;
  } result_t;

  function automatic logic [2:0] fmt_bytes(fmt_t f);
    logic [2:0] n;
    case (f)
      FMT_RGBA8888: n = 3'd4;
      FMT_RGB888:   n = 3'd3;
      FMT_A8,
      FMT_I8:       n = 3'd1;
      default:      n = 3'd2;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/core/pfc_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for source pixels and converted results.
interface pfc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic       last_pixel;

  modport source (output valid, output byte0, output byte1, output byte2, output byte3,
                  output last_pixel, input ready);
  modport sink (input valid, input byte0, input byte1, input byte2, input byte3,
                input last_pixel, output ready);
endinterface

interface pfc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic [2:0]  out_bytes;
  logic [2:0]  format_used;
  logic        fell_back;
  logic        last_out;

  modport source (output valid, output pixel_word, output out_bytes, output format_used,
                  output fell_back, output last_out, input ready);
  modport sink (input valid, input pixel_word, input out_bytes, input format_used,
                input fell_back, input last_out, output ready);
endinterface

>>> rtl/core/pfc_apb_regs.sv
`timescale 1ns / 1ps
// APB register block holding the source and target format selects.
module pfc_apb_regs
  import pfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_format <= FMT_RGBA8888;
      cfg.target_format <= FMT_RGBA8888;
    end else if (wr) begin
      case (idx)
        REG_SOURCE_FORMAT: cfg.source_format <= fmt_t'(pwdata[2:0]);
        REG_TARGET_FORMAT: cfg.target_format <= fmt_t'(pwdata[2:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SOURCE_FORMAT: prdata = {29'b0, cfg.source_format};
      REG_TARGET_FORMAT: prdata = {29'b0, cfg.target_format};
      default:           prdata = 32'b0;
    endcase
  end

endmodule

>>> rtl/core/pfc_luma.sv
`timescale 1ns / 1ps
// Rounded luminance: registered weighted sum, then reciprocal-multiply divide by 1000.
module pfc_luma
  import pfc_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] r,
  input  logic [7:0] g,
  input  logic [7:0] b,
  output logic [7:0] luma
);

  logic [LUMA_SUM_W-1:0]  sum;
  logic [LUMA_SUM_W-1:0]  sum_next;
  logic [LUMA_PROD_W-1:0] prod;

  assign sum_next = LUMA_SUM_W'(r) * LUMA_WR + LUMA_SUM_W'(g) * LUMA_WG
                  + LUMA_SUM_W'(b) * LUMA_WB + LUMA_ROUND;

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= sum_next;
    end
  end

  assign prod = {{LUMA_RECIP_W{1'b0}}, sum} * {{LUMA_SUM_W{1'b0}}, LUMA_RECIP};
  assign luma = prod[LUMA_SHIFT +: 8];

endmodule

>>> rtl/core/pfc_pack.sv
`timescale 1ns / 1ps
// Format selection and channel packing for one pixel.
module pfc_pack
  import pfc_pkg::*;
(
  input  cfg_t       cfg,
  input  pixel_t     pix,
  input  logic [7:0] luma,
  output result_t    res
);

  fmt_t        src;
  fmt_t        dst;
  logic        gray_src;
  logic        rgb_src;
  logic        has_alpha;
  logic [7:0]  cr;
  logic [7:0]  cg;
  logic [7:0]  cb;
  logic [7:0]  al;
  logic [7:0]  lum;
  logic [31:0] word;
  logic [31:0] raw;
  logic        ok;

  assign src = cfg.source_format;
  assign dst = cfg.target_format;

  always_comb begin
    gray_src  = src inside {FMT_I8, FMT_AI88};
    rgb_src   = src inside {FMT_RGB888, FMT_RGBA8888};
    has_alpha = src inside {FMT_AI88, FMT_RGBA8888};

    if (gray_src) begin
      cr  = pix.byte0;
      cg  = pix.byte0;
      cb  = pix.byte0;
      lum = pix.byte0;
      al  = (src == FMT_AI88) ? pix.byte1 : ALPHA_OPAQUE;
    end else begin
      cr  = pix.byte0;
      cg  = pix.byte1;
      cb  = pix.byte2;
      lum = luma;
      al  = (src == FMT_RGBA8888) ? pix.byte3 : ALPHA_OPAQUE;
    end

    case (dst)
      FMT_RGBA8888: word = {al, cb, cg, cr};
      FMT_RGB888:   word = {8'b0, cb, cg, cr};
      FMT_RGB565:   word = {16'b0, cr[7:3], cg[7:2], cb[7:3]};
      FMT_RGBA4444: word = {16'b0, cr[7:4], cg[7:4], cb[7:4], al[7:4]};
      FMT_RGB5A1:   word = {16'b0, cr[7:3], cg[7:3], cb[7:3], al[7]};
      FMT_AI88:     word = {16'b0, al, lum};
      FMT_A8:       word = {24'b0, al};
      FMT_I8:       word = {24'b0, lum};
      default:      word = 32'b0;
    endcase

    ok = (gray_src || rgb_src) && (src != dst) && !(dst == FMT_A8 && !has_alpha);

    case (fmt_bytes(src))
      3'd1:    raw = {24'b0, pix.byte0};
      3'd2:    raw = {16'b0, pix.byte1, pix.byte0};
      3'd3:    raw = {8'b0, pix.byte2, pix.byte1, pix.byte0};
      default: raw = {pix.byte3, pix.byte2, pix.byte1, pix.byte0};
    endcase

    res.last_out = pix.last_pixel;
    if (ok) begin
      res.pixel_word  = word;
      res.out_bytes   = fmt_bytes(dst);
      res.format_used = dst;
      res.fell_back   = 1'b0;
    end else begin
      res.pixel_word  = raw;
      res.out_bytes   = fmt_bytes(src);
      res.format_used = src;
      res.fell_back   = (src != dst);
    end
  end

endmodule

>>> rtl/core/pixel_format_converter_top.sv
`timescale 1ns / 1ps
// Top level of the pixel format converter: APB registers and three-stage pixel pipeline.
//
// Converts one pixel per clock from the selected source format to the selected
// target format. A request passes an input register, a luminance-sum register and
// the result register, and the pipe sustains one pixel per cycle while the result
// side keeps up; a stall on the result side backs up through the three stages.
// Program the two format registers only while no pixel is in flight.
module pixel_format_converter_top
  import pfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  pfc_pixel_if.sink          pixel_in,
  pfc_result_if.source       result_out
);

  cfg_t       cfg;
  pixel_t     s1;
  pixel_t     s2;
  result_t    res;
  result_t    res_next;
  logic [7:0] luma;
  logic       s1_valid;
  logic       s2_valid;
  logic       out_valid;
  logic       in_acc;
  logic       s2_load;
  logic       out_load;

  pfc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_load = s2_valid && (!out_valid || result_out.ready);
  assign s2_load  = s1_valid && (!s2_valid || out_load);
  assign pixel_in.ready = !s1_valid || s2_load;
  assign in_acc   = pixel_in.valid && pixel_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_acc || (s1_valid && !s2_load);
      s2_valid  <= s2_load || (s2_valid && !out_load);
      out_valid <= out_load || (out_valid && !result_out.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1 <= '{byte0: pixel_in.byte0, byte1: pixel_in.byte1, byte2: pixel_in.byte2,
              byte3: pixel_in.byte3, last_pixel: pixel_in.last_pixel};
    end
    if (s2_load) begin
      s2 <= s1;
    end
    if (out_load) begin
      res <= res_next;
    end
  end

  pfc_luma u_luma (
    .clk  (clk),
    .en   (s2_load),
    .r    (s1.byte0),
    .g    (s1.byte1),
    .b    (s1.byte2),
    .luma (luma)
  );

  pfc_pack u_pack (
    .cfg  (cfg),
    .pix  (s2),
    .luma (luma),
    .res  (res_next)
  );

  assign result_out.valid       = out_valid;
  assign result_out.pixel_word  = res.pixel_word;
  assign result_out.out_bytes   = res.out_bytes;
  assign result_out.format_used = res.format_used;
  assign result_out.fell_back   = res.fell_back;
  assign result_out.last_out    = res.last_out;

  a_fallback_src: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.fell_back) |-> (res.format_used == cfg.source_format))
    else $error("fallback result does not report the source format");

  a_bytes_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res.out_bytes == fmt_bytes(res.format_used)))
    else $error("byte count does not match produced format");

  a_packed_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.out_bytes == 3'd2) |-> (res.pixel_word[31:16] == 16'b0))
    else $error("16-bit result has nonzero upper bytes");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_out.ready && !s2_valid) |=> !out_valid)
    else $error("result valid without a pending request");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    s2_load |=> s2_valid)
    else $error("luminance stage lost a request");

endmodule
